/* src/sal_pkg.sv */
// ----------------------------------------------------------------------------
// sal_pkg
// shared constants, register indexes, brightness table and control structs
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int unsigned HourW    = 5;
	localparam int unsigned MinuteW  = 6;
	localparam int unsigned RampW    = 8;
	localparam int unsigned DutyW    = 8;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 8;
	localparam int unsigned MinOfDayW = 12;
	localparam int unsigned QuoW     = 5;
	localparam int unsigned DivCntW  = 3;

	localparam logic [DutyW-1:0]   FullDuty  = 8'd255;
	localparam logic [DutyW-1:0]   OffDuty   = 8'd0;
	localparam logic [DivCntW-1:0] DivTopBit = 3'd4;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FIRST_HOUR    = 3'd0,
		REG_FIRST_MINUTE  = 3'd1,
		REG_FIRST_RAMP    = 3'd2,
		REG_FIRST_ENABLE  = 3'd3,
		REG_SECOND_HOUR   = 3'd4,
		REG_SECOND_MINUTE = 3'd5,
		REG_SECOND_RAMP   = 3'd6,
		REG_SECOND_ENABLE = 3'd7
	} sal_reg_t;

	typedef enum logic {
		OP_TIME    = 1'b0,
		OP_DISMISS = 1'b1
	} sal_op_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic step;
		logic sel;
	} sal_cmd_t;

	typedef struct packed {
		logic dismiss;
		logic div_last;
	} sal_stat_t;

	function automatic logic [DutyW-1:0] glow_lut(input logic [QuoW-1:0] idx);
		logic [DutyW-1:0] v;
		case (idx)
			5'd0:    v = 8'd1;
			5'd1:    v = 8'd1;
			5'd2:    v = 8'd2;
			5'd3:    v = 8'd2;
			5'd4:    v = 8'd3;
			5'd5:    v = 8'd3;
			5'd6:    v = 8'd4;
			5'd7:    v = 8'd5;
			5'd8:    v = 8'd6;
			5'd9:    v = 8'd7;
			5'd10:   v = 8'd8;
			5'd11:   v = 8'd9;
			5'd12:   v = 8'd10;
			5'd13:   v = 8'd20;
			5'd14:   v = 8'd100;
			5'd15:   v = 8'd250;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

endpackage

/* src/sal_ctrl.sv */
// ----------------------------------------------------------------------------
// sal_ctrl
// sequencer: capture, window evaluation, two divide passes (skipped on dismiss), result beat
// ----------------------------------------------------------------------------
module sal_ctrl
	import sal_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  sal_stat_t stat,
	output sal_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV0,
		ST_DIV1,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && in_ready_q;
		case (state_q)
			ST_EVAL: cmd.eval = 1'b1;
			ST_DIV0: cmd.step = 1'b1;
			ST_DIV1: begin
				cmd.step = 1'b1;
				cmd.sel  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_EVAL;
						in_ready_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					if (stat.dismiss) begin
						state_q     <= ST_RESULT;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= ST_DIV0;
					end
				end
				ST_DIV0: begin
					if (stat.div_last) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (stat.div_last) begin
						state_q     <= ST_RESULT;
						out_valid_q <= 1'b1;
					end
				end
				ST_RESULT: begin
					if (out_ready) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_ready_valid_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready_q && out_valid_q))
		else $error("input ready while result pending");

	a_out_beat_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready) |=> in_ready_q)
		else $error("input not reopened after result beat");

	a_capture_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (!in_ready_q && !out_valid_q))
		else $error("handshake state wrong after input beat");

	a_step_has_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!in_ready_q && !out_valid_q))
		else $error("divide step overlaps a handshake");
`endif

endmodule

/* src/sal_dp.sv */
// ----------------------------------------------------------------------------
// sal_dp
// config registers, window compare, shared restoring divider, duty and flags
// ----------------------------------------------------------------------------
module sal_dp
	import sal_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                op,
	input  logic [HourW-1:0]    current_hour,
	input  logic [MinuteW-1:0]  current_minute,
	input  logic                alarm_choice,
	input  sal_cmd_t            cmd,
	output sal_stat_t           stat,
	output logic [DutyW-1:0]    light_duty,
	output logic                first_ramping,
	output logic                second_ramping
);

	logic [HourW-1:0]   hour0_q, hour1_q;
	logic [MinuteW-1:0] min0_q, min1_q;
	logic [RampW-1:0]   ramp0_q, ramp1_q;
	logic               en0_q, en1_q;

	logic               op_q;
	logic [HourW-1:0]   cur_hour_q;
	logic [MinuteW-1:0] cur_min_q;
	logic               choice_q;

	logic [1:0]         awake_q;
	logic [DutyW-1:0]   duty_q;
	logic               r0_q, r1_q;
	logic [RampW-1:0]   step1_q;

	logic [MinOfDayW-1:0] div_rem_q;
	logic [RampW-1:0]     div_ramp_q;
	logic [DivCntW-1:0]   div_k_q;
	logic [QuoW-1:0]      div_quo_q;

	function automatic logic [MinOfDayW-1:0] to_minutes(input logic [HourW-1:0] h,
		input logic [MinuteW-1:0] m);
		logic [MinOfDayW-1:0] r;
		r = {1'b0, h, 6'b0} - {5'b0, h, 2'b0} + {6'b0, m};
		return r;
	endfunction

	logic [MinOfDayW-1:0] now_min;
	logic signed [MinOfDayW:0] start0, start1, diff0, diff1;
	logic win0, win1;

	always_comb begin
		now_min = to_minutes(cur_hour_q, cur_min_q);
		start0  = $signed({1'b0, to_minutes(hour0_q, min0_q)})
			- $signed({5'b0, ramp0_q}) - 13'sd1;
		start1  = $signed({1'b0, to_minutes(hour1_q, min1_q)})
			- $signed({5'b0, ramp1_q}) - 13'sd1;
		diff0   = $signed({1'b0, now_min}) - start0;
		diff1   = $signed({1'b0, now_min}) - start1;
		win0    = en0_q && !start0[MinOfDayW] && (diff0 > 13'sd0)
			&& (diff0 <= $signed({5'b0, ramp0_q}));
		win1    = en1_q && !start1[MinOfDayW] && (diff1 > 13'sd0)
			&& (diff1 <= $signed({5'b0, ramp1_q}));
	end

	// one restoring divide iteration per cycle, quotient never exceeds 16 for a ramping alarm
	logic [MinOfDayW-1:0] div_shift;
	logic [MinOfDayW:0]   div_trial;
	logic                 div_fits;
	logic [QuoW-1:0]      quo_next;
	logic                 sel_ramping;

	always_comb begin
		div_shift   = {4'b0, div_ramp_q} << div_k_q;
		div_trial   = {1'b0, div_rem_q} - {1'b0, div_shift};
		div_fits    = !div_trial[MinOfDayW];
		quo_next    = div_quo_q | (div_fits ? (QuoW'(1) << div_k_q) : '0);
		sel_ramping = cmd.sel ? r1_q : r0_q;
	end

	assign stat.dismiss  = (op_q == OP_DISMISS);
	assign stat.div_last = (div_k_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour0_q <= '0;
			min0_q  <= '0;
			ramp0_q <= '0;
			en0_q   <= 1'b0;
			hour1_q <= '0;
			min1_q  <= '0;
			ramp1_q <= '0;
			en1_q   <= 1'b0;
			awake_q <= '0;
			duty_q  <= FullDuty;
			r0_q    <= 1'b0;
			r1_q    <= 1'b0;
			div_k_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_HOUR:    hour0_q <= cfg_data[HourW-1:0];
					REG_FIRST_MINUTE:  min0_q  <= cfg_data[MinuteW-1:0];
					REG_FIRST_RAMP:    ramp0_q <= cfg_data[RampW-1:0];
					REG_FIRST_ENABLE:  en0_q   <= cfg_data[0];
					REG_SECOND_HOUR:   hour1_q <= cfg_data[HourW-1:0];
					REG_SECOND_MINUTE: min1_q  <= cfg_data[MinuteW-1:0];
					REG_SECOND_RAMP:   ramp1_q <= cfg_data[RampW-1:0];
					REG_SECOND_ENABLE: en1_q   <= cfg_data[0];
					default: ;
				endcase
			end

			if (cmd.eval) begin
				if (op_q == OP_DISMISS) begin
					awake_q[choice_q] <= 1'b0;
					duty_q            <= OffDuty;
					r0_q              <= 1'b0;
					r1_q              <= 1'b0;
				end else begin
					r0_q <= win0;
					r1_q <= win1;
					if (win0) awake_q[0] <= 1'b1;
					if (win1) awake_q[1] <= 1'b1;
					div_k_q <= DivTopBit;
				end
			end

			if (cmd.step) begin
				if (div_k_q == '0) begin
					if (sel_ramping) begin
						duty_q <= glow_lut(quo_next);
					end else if (awake_q[cmd.sel]) begin
						duty_q <= FullDuty;
					end
					if (!cmd.sel) begin
						div_k_q <= DivTopBit;
					end
				end else begin
					div_k_q <= div_k_q - 3'd1;
				end
			end
		end
	end

	// payload and divider registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op;
			cur_hour_q <= current_hour;
			cur_min_q  <= current_minute;
			choice_q   <= alarm_choice;
		end
		if (cmd.eval) begin
			div_rem_q  <= {diff0[RampW-1:0], 4'b0};
			div_ramp_q <= ramp0_q;
			div_quo_q  <= '0;
			step1_q    <= diff1[RampW-1:0];
		end
		if (cmd.step) begin
			if (div_k_q == '0 && !cmd.sel) begin
				div_rem_q  <= {step1_q, 4'b0};
				div_ramp_q <= ramp1_q;
				div_quo_q  <= '0;
			end else begin
				if (div_fits) begin
					div_rem_q <= div_trial[MinOfDayW-1:0];
				end
				div_quo_q <= quo_next;
			end
		end
	end

	assign light_duty     = duty_q;
	assign first_ramping  = r0_q;
	assign second_ramping = r1_q;

`ifndef SYNTHESIS
	a_dismiss_clears_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && op_q == OP_DISMISS) |=> (!r0_q && !r1_q && duty_q == OffDuty))
		else $error("dismiss left ramp flags or duty set");

	a_ramp_sets_awake: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && op_q == OP_TIME) |=> ((!r0_q || awake_q[0]) && (!r1_q || awake_q[1])))
		else $error("ramping alarm without awake flag");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sel_ramping && div_k_q == '0) |-> (quo_next <= 5'd16))
		else $error("table index out of range");
`endif

endmodule

/* src/sunrise_alarm_light_ramp.sv */
// time update: input beat, window evaluation, two divide passes, then the result beat;
// dismiss skips the divide passes. A new input is not taken before the last result beat,
// the divide passes use one shared 5-step divider run once for each alarm
// input is taken again the cycle after the result beat
// reset: alarms disabled, config cleared, awake flags clear, duty at 255
// ----------------------------------------------------------------------------
// sunrise_alarm_light_ramp
// two-alarm wake light dimmer, lamp duty from ramp position
// ----------------------------------------------------------------------------
module sunrise_alarm_light_ramp
	import sal_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [HourW-1:0]    current_hour,
	input  logic [MinuteW-1:0]  current_minute,
	input  logic                alarm_choice,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DutyW-1:0]    light_duty,
	output logic                first_ramping,
	output logic                second_ramping
);

	sal_cmd_t  cmd;
	sal_stat_t stat;

	assign cfg_ready = 1'b1;

	sal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sal_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.current_hour   (current_hour),
		.current_minute (current_minute),
		.alarm_choice   (alarm_choice),
		.cmd            (cmd),
		.stat           (stat),
		.light_duty     (light_duty),
		.first_ramping  (first_ramping),
		.second_ramping (second_ramping)
	);

endmodule
